>>> sv/tdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tdp_pkg;
	localparam int FRAC_BITS = 15;
	localparam int BETA_FRAC = 8;
	localparam int IN_W = 17;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_W = 16;
	localparam int CFG_W = 16;
	localparam int IDX_W = 2;
	localparam int Y_W = 40;
	localparam int N_W = Y_W - 32;
	localparam int PROD_W = CFG_W + 33;

	localparam logic [IDX_W-1:0] REG_SHARPNESS = 2'd0;
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_W-1:0] SHARPNESS_RST = 16'd256;
	localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd32768;

	localparam logic [32:0] ONE = 33'h1_0000_0000;
	localparam logic [IN_W-1:0] IN_ONE = IN_W'(1) << FRAC_BITS;
	localparam logic [OUT_W:0] OUT_ONE = (OUT_W + 1)'(1) << FRAC_BITS;

	localparam int EXP_TERMS = 20;
	localparam int EXP_CUTOFF = 23;
	localparam int SER_STAGES = 3 * (EXP_TERMS - 1);
	localparam int POW_STAGES = EXP_CUTOFF - 1;
	localparam int DIV_STEP = 4;
	localparam int DIV_STAGES = 32 / DIV_STEP;

	// floor(2^32 / k), used for truncating division by the series index
	localparam logic [31:0] RECIP [EXP_TERMS+1] = '{
		32'd0, 32'd0,
		32'(ONE / 33'd2), 32'(ONE / 33'd3), 32'(ONE / 33'd4), 32'(ONE / 33'd5),
		32'(ONE / 33'd6), 32'(ONE / 33'd7), 32'(ONE / 33'd8), 32'(ONE / 33'd9),
		32'(ONE / 33'd10), 32'(ONE / 33'd11), 32'(ONE / 33'd12), 32'(ONE / 33'd13),
		32'(ONE / 33'd14), 32'(ONE / 33'd15), 32'(ONE / 33'd16), 32'(ONE / 33'd17),
		32'(ONE / 33'd18), 32'(ONE / 33'd19), 32'(ONE / 33'd20)
	};

	typedef struct packed {
		logic        err;
		logic        lower;
		logic        zero;
		logic [31:0] eta;
		logic [32:0] u;
	} side_t;

	// q0.32 product, an operand of one passes the other through
	function automatic logic [32:0] mul32(input logic [32:0] a, input logic [32:0] b);
		logic [63:0] p;
		p = {32'd0, a[31:0]} * {32'd0, b[31:0]};
		if (a >= ONE) return b;
		if (b >= ONE) return a;
		return {1'b0, p[63:32]};
	endfunction

	function automatic logic [31:0] div_small(input logic [31:0] p, input int k);
		logic [63:0] m;
		logic [31:0] q0;
		logic [31:0] r;
		m = {32'd0, p} * {32'd0, RECIP[k]};
		q0 = m[63:32];
		r = p - 32'(q0 * 32'(k));
		if (r >= 32'(k)) q0 = q0 + 32'd1;
		return q0;
	endfunction

	function automatic logic [32:0] exp_frac_c(input logic [31:0] f);
		logic [33:0] sum;
		logic [31:0] term;
		logic [63:0] p;
		sum = 34'(ONE) - 34'(f);
		term = f;
		for (int k = 2; k <= EXP_TERMS; k++) begin
			p = {32'd0, term} * {32'd0, f};
			term = div_small(p[63:32], k);
			if (k[0]) begin
				sum = (sum >= 34'(term)) ? sum - 34'(term) : '0;
			end else begin
				sum = sum + 34'(term);
			end
		end
		if (sum > 34'(ONE)) sum = 34'(ONE);
		return sum[32:0];
	endfunction

	localparam logic [32:0] E_HALF = exp_frac_c(32'h8000_0000);
	localparam logic [32:0] E_NEG1 = mul32(E_HALF, E_HALF);
endpackage
`default_nettype wire

>>> sv/tdp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tdp_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_valid,
	input  wire logic [32:0]         in_num,
	input  wire logic [32:0]         in_den,
	input  wire tdp_pkg::side_t      in_side,
	output logic                     out_valid,
	output logic [32:0]              out_q,
	output tdp_pkg::side_t           out_side
);
	import tdp_pkg::*;

	typedef struct packed {
		logic [32:0] rem;
		logic [32:0] den;
		logic [31:0] q;
		logic        sat;
	} div_t;

	logic [DIV_STAGES:0] v_s;
	div_t                d_s [DIV_STAGES+1];
	side_t               side_s [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[DIV_STAGES-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0].rem <= in_num;
			d_s[0].den <= in_den;
			d_s[0].q <= '0;
			d_s[0].sat <= (in_num >= in_den);
			side_s[0] <= in_side;
			for (int s = 1; s <= DIV_STAGES; s++) side_s[s] <= side_s[s-1];
		end
	end

	for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_stage
		div_t nx;
		always_comb begin
			logic [33:0] t;
			nx = d_s[j-1];
			for (int b = 0; b < DIV_STEP; b++) begin
				t = {nx.rem, 1'b0};
				if (t >= 34'(nx.den)) begin
					nx.rem = 33'(t - 34'(nx.den));
					nx.q = {nx.q[30:0], 1'b1};
				end else begin
					nx.rem = t[32:0];
					nx.q = {nx.q[30:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) d_s[j] <= nx;
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign out_q = d_s[DIV_STAGES].sat ? ONE : {1'b0, d_s[DIV_STAGES].q};
	assign out_side = side_s[DIV_STAGES];
endmodule
`default_nettype wire

>>> sv/tdp_exp.sv
`timescale 1ns / 1ps
`default_nettype none
module tdp_exp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           in_valid,
	input  wire logic [1:0][tdp_pkg::Y_W-1:0]   in_y,
	input  wire tdp_pkg::side_t                 in_side,
	output logic                                out_valid,
	output logic [1:0][32:0]                    out_e,
	output tdp_pkg::side_t                      out_side
);
	import tdp_pkg::*;

	localparam int DEPTH = 1 + SER_STAGES + POW_STAGES;

	typedef struct packed {
		logic [31:0]    f;
		logic [31:0]    pp;
		logic [31:0]    term;
		logic [32:0]    sum;
		logic [N_W-1:0] n;
	} ser_t;

	typedef struct packed {
		logic [32:0]    r;
		logic [N_W-1:0] n;
	} pow_t;

	logic [DEPTH-1:0] v_s;
	side_t            side_s [DEPTH];
	ser_t             ser_s [SER_STAGES+1][2];
	pow_t             pow_s [POW_STAGES][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= in_side;
			for (int s = 1; s < DEPTH; s++) side_s[s] <= side_s[s-1];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				ser_s[0][l].f <= in_y[l][31:0];
				ser_s[0][l].pp <= '0;
				ser_s[0][l].term <= in_y[l][31:0];
				ser_s[0][l].sum <= ONE - 33'(in_y[l][31:0]);
				ser_s[0][l].n <= in_y[l][Y_W-1:32];
			end
		end

		// each series term takes three stages: product, reciprocal, correction
		for (genvar j = 1; j <= SER_STAGES; j++) begin : g_ser
			localparam int K = 2 + (j - 1) / 3;
			localparam int PH = (j - 1) % 3;
			ser_t nx;
			if (PH == 0) begin : g_prod
				always_comb begin
					logic [63:0] p;
					nx = ser_s[j-1][l];
					p = {32'd0, nx.term} * {32'd0, nx.f};
					nx.pp = p[63:32];
				end
			end else if (PH == 1) begin : g_recip
				always_comb begin
					logic [63:0] p;
					nx = ser_s[j-1][l];
					p = {32'd0, nx.pp} * {32'd0, RECIP[K]};
					nx.term = p[63:32];
				end
			end else begin : g_corr
				always_comb begin
					logic [31:0] r;
					logic [31:0] t;
					nx = ser_s[j-1][l];
					r = nx.pp - 32'(nx.term * 32'(K));
					t = (r >= 32'(K)) ? nx.term + 32'd1 : nx.term;
					nx.term = t;
					if (K % 2 == 1) begin
						nx.sum = (nx.sum >= 33'(t)) ? nx.sum - 33'(t) : '0;
					end else begin
						nx.sum = nx.sum + 33'(t);
					end
				end
			end
			always_ff @(posedge clk) begin
				if (adv) ser_s[j][l] <= nx;
			end
		end

		// repeated multiply by exp(-1) for the integer part
		for (genvar i = 0; i < POW_STAGES; i++) begin : g_pow
			pow_t src;
			pow_t nx;
			if (i == 0) begin : g_first
				always_comb begin
					src.r = (ser_s[SER_STAGES][l].sum > ONE) ? ONE : ser_s[SER_STAGES][l].sum;
					src.n = ser_s[SER_STAGES][l].n;
				end
			end else begin : g_next
				assign src = pow_s[i-1][l];
			end
			always_comb begin
				nx.n = src.n;
				nx.r = (src.n > N_W'(i)) ? mul32(src.r, E_NEG1) : src.r;
			end
			always_ff @(posedge clk) begin
				if (adv) pow_s[i][l] <= nx;
			end
		end

		assign out_e[l] = (pow_s[POW_STAGES-1][l].n >= N_W'(EXP_CUTOFF)) ? '0
			: pow_s[POW_STAGES-1][l].r;
	end

	assign out_valid = v_s[DEPTH-1];
	assign out_side = side_s[DEPTH-1];
endmodule
`default_nettype wire

>>> sv/tdp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tdp_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic                       in_valid,
	input  wire logic [32:0]                in_e,
	input  wire logic [32:0]                in_eb,
	input  wire tdp_pkg::side_t             in_side,
	output logic                            out_valid,
	output logic [tdp_pkg::OUT_W-1:0]       out_density,
	output logic                            out_err
);
	import tdp_pkg::*;

	logic [4:1]       v_s;
	side_t            side_s1, side_s2, side_s3;
	logic [32:0]      e_s1, ue_s1;
	logic [32:0]      g_s2, den_s2;
	logic [32:0]      m_s3;
	logic [OUT_W-1:0] dens_s4;
	logic             err_s4;

	logic [32:0] g_nx;
	logic [33:0] gu;
	logic [33:0] r_sum;
	logic [33:0] r_cl;
	logic [33:0] q_sum;
	logic [OUT_W:0] q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[3:1], in_valid};
		end
	end

	always_comb begin
		gu = 34'(ONE) + 34'(ue_s1) - 34'(e_s1);
		if (side_s1.lower) begin
			g_nx = (e_s1 > ue_s1) ? e_s1 - ue_s1 : '0;
		end else begin
			g_nx = (gu > 34'(ONE)) ? ONE : gu[32:0];
		end
	end

	always_comb begin
		r_sum = 34'(m_s3) + (side_s3.lower ? 34'd0 : 34'(side_s3.eta));
		r_cl = (r_sum > 34'(ONE)) ? 34'(ONE) : r_sum;
		if (side_s3.zero) r_cl = '0;
		q_sum = r_cl + (34'd1 << (31 - FRAC_BITS));
		q = (OUT_W + 1)'(q_sum >> (32 - FRAC_BITS));
		if (q > OUT_ONE) q = OUT_ONE;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= in_side;
			e_s1 <= in_e;
			ue_s1 <= mul32(in_side.u, in_eb);
			side_s2 <= side_s1;
			g_s2 <= g_nx;
			den_s2 <= side_s1.lower ? {1'b0, side_s1.eta} : ONE - 33'(side_s1.eta);
			side_s3 <= side_s2;
			m_s3 <= mul32(den_s2, g_s2);
			err_s4 <= side_s3.err;
			dens_s4 <= side_s3.err ? '0 : q[OUT_W-1:0];
		end
	end

	assign out_valid = v_s[4];
	assign out_density = dens_s4;
	assign out_err = err_s4;
endmodule
`default_nettype wire

>>> sv/threshold_density_projection_core.sv
// throughput: one item per cycle while the output buffer has room, set by the fully
//   pipelined divider, series and exp(-1) power stages; a two-entry output buffer holds
//   results while the sink stalls, and s_axis_tready drops while both entries are full
// reset: arst_n clears all valid bits and the buffer and loads sharpness 1.0 and threshold 0.5
`timescale 1ns / 1ps
`default_nettype none
module threshold_density_projection_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [tdp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [16:0] density_in
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [tdp_pkg::OUT_W-1:0]            m_axis_tdata,  // [15:0] density_out
	output logic                                 m_axis_tuser,  // [0] range_error
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tdp_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [tdp_pkg::CFG_W-1:0]       cfg_data
);
	import tdp_pkg::*;

	typedef struct packed {
		logic             err;
		logic [OUT_W-1:0] dens;
	} out_t;

	logic [CFG_W-1:0] sharp_q, thr_q;
	logic             v_s1;
	logic [IN_W-1:0]  raw_s1;

	logic        adv;
	logic [32:0] x32, eta33, num, den;
	logic        lower;
	side_t       side_in;

	logic        dv;
	logic [32:0] dq;
	side_t       dside, eside_in;
	logic [1:0][Y_W-1:0] y;
	logic [PROD_W-1:0]   beta_u;

	logic            ev;
	logic [1:0][32:0] e;
	side_t           eside;

	logic             bv;
	logic [OUT_W-1:0] bdens;
	logic             berr;

	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	out_t       buf_q [2];
	logic       push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sharp_q <= SHARPNESS_RST;
			thr_q <= THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SHARPNESS: sharp_q <= cfg_data;
				REG_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = (cnt_q != 2'd2);
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) raw_s1 <= s_axis_tdata[IN_W-1:0];
	end

	always_comb begin
		x32 = 33'(raw_s1[IN_W-2:0]) << (32 - FRAC_BITS);
		eta33 = {1'b0, thr_q, (32 - CFG_W)'(0)};
		lower = (x32 <= eta33);
		num = lower ? eta33 - x32 : x32 - eta33;
		den = lower ? eta33 : ONE - eta33;
		side_in.err = (raw_s1 > IN_ONE);
		side_in.lower = lower;
		side_in.zero = lower && (eta33 == '0);
		side_in.eta = eta33[31:0];
		side_in.u = '0;
	end

	tdp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s1),
		.in_num    (num),
		.in_den    (den),
		.in_side   (side_in),
		.out_valid (dv),
		.out_q     (dq),
		.out_side  (dside)
	);

	// lane 0 is exp(-beta*u), lane 1 is exp(-beta)
	always_comb begin
		beta_u = PROD_W'(sharp_q) * PROD_W'(dq);
		y[0] = Y_W'(beta_u >> BETA_FRAC);
		y[1] = Y_W'(sharp_q) << (32 - BETA_FRAC);
		eside_in = dside;
		eside_in.u = dq;
	end

	tdp_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (dv),
		.in_y      (y),
		.in_side   (eside_in),
		.out_valid (ev),
		.out_e     (e),
		.out_side  (eside)
	);

	tdp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (ev),
		.in_e        (e[0]),
		.in_eb       (e[1]),
		.in_side     (eside),
		.out_valid   (bv),
		.out_density (bdens),
		.out_err     (berr)
	);

	assign push = adv && bv;
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q].err <= berr;
			buf_q[wr_q].dens <= bdens;
		end
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata = buf_q[rd_q].dens;
	assign m_axis_tuser = buf_q[rd_q].err;
endmodule
`default_nettype wire

>>> sv/tdp_sva.sv
`timescale 1ns / 1ps
`default_nettype none
module tdp_sva (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        m_axis_tvalid,
	input wire logic                        m_axis_tready,
	input wire logic [tdp_pkg::OUT_W-1:0]   m_axis_tdata,
	input wire logic                        m_axis_tuser
);
	import tdp_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output payload changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("range error with nonzero density");

	a_max_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> {1'b0, m_axis_tdata} <= OUT_ONE)
		else $error("projected density above one");
endmodule

bind threshold_density_projection_core tdp_sva u_tdp_sva (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
class projection_scoreboard;
	logic [15:0] beta;
	logic [15:0] eta;
	logic [16:0] exp_q[$];
	int mismatches;
	int results_seen;
	int errors_seen;

	function new();
		beta = tdp_pkg::SHARPNESS_RST;
		eta = tdp_pkg::THRESHOLD_RST;
		mismatches = 0;
		results_seen = 0;
		errors_seen = 0;
	endfunction

	function logic [63:0] q32_mul(logic [63:0] a, logic [63:0] b);
		if (a >= 64'h1_0000_0000) return b;
		if (b >= 64'h1_0000_0000) return a;
		return (a * b) >> 32;
	endfunction

	function logic [63:0] exp_frac(logic [63:0] f);
		logic [63:0] sum;
		logic [63:0] term;
		sum = 64'h1_0000_0000 - f;
		term = f;
		for (int k = 2; k <= 20; k++) begin
			term = ((term * f) >> 32) / k;
			if (k % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
			else sum = sum + term;
		end
		if (sum > 64'h1_0000_0000) sum = 64'h1_0000_0000;
		return sum;
	endfunction

	function logic [63:0] exp_decay(logic [63:0] y);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] e1;
		logic [63:0] h;
		n = y >> 32;
		if (n >= 23) return 64'd0;
		r = exp_frac({32'd0, y[31:0]});
		h = exp_frac(64'h8000_0000);
		e1 = q32_mul(h, h);
		for (int i = 0; i < n; i++) r = q32_mul(r, e1);
		return r;
	endfunction

	// returns {range_error, density_out}
	function logic [16:0] project(logic [16:0] raw);
		logic [63:0] one32, x32, eta32, eb, r32, q, d, u, e, ue, g, den;
		one32 = 64'h1_0000_0000;
		if (raw[16] || raw > 17'd32768) return {1'b1, 16'd0};
		x32 = {47'd0, raw} << 17;
		eta32 = {48'd0, eta} << 16;
		eb = exp_decay(({48'd0, beta} * one32) >> 8);
		if (x32 <= eta32) begin
			if (eta32 == 0) begin
				r32 = 0;
			end else begin
				d = eta32 - x32;
				u = (d >= eta32) ? one32 : (d << 32) / eta32;
				e = exp_decay(({48'd0, beta} * u) >> 8);
				ue = q32_mul(u, eb);
				g = (e > ue) ? e - ue : 64'd0;
				if (g > one32) g = one32;
				r32 = q32_mul(eta32, g);
			end
		end else begin
			den = one32 - eta32;
			d = x32 - eta32;
			u = (d >= den) ? one32 : (d << 32) / den;
			e = exp_decay(({48'd0, beta} * u) >> 8);
			g = one32 - e + q32_mul(u, eb);
			if (g > one32) g = one32;
			r32 = q32_mul(den, g) + eta32;
		end
		if (r32 > one32) r32 = one32;
		q = (r32 + 64'h1_0000) >> 17;
		if (q > 64'd32768) q = 64'd32768;
		return {1'b0, q[15:0]};
	endfunction

	function void note_density(logic [16:0] raw);
		exp_q.push_back(project(raw));
	endfunction

	function void write_reg(logic [1:0] idx, logic [15:0] val);
		if (idx == tdp_pkg::REG_SHARPNESS) beta = val;
		else if (idx == tdp_pkg::REG_THRESHOLD) eta = val;
	endfunction

	function void check_projection(logic [15:0] dens, logic err);
		logic [16:0] want;
		results_seen++;
		if (err) errors_seen++;
		if (exp_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result density %0d error %0b", dens, err);
			return;
		end
		want = exp_q.pop_front();
		if (want[15:0] !== dens || want[16] !== err) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch beta %0d eta %0d: expected %0d/%0b got %0d/%0b",
					beta, eta, want[15:0], want[16], dens, err);
		end
	endfunction
endclass

module testbench;
	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [tdp_pkg::IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [tdp_pkg::OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [tdp_pkg::IDX_W-1:0] cfg_index;
	logic [tdp_pkg::CFG_W-1:0] cfg_data;

	projection_scoreboard sb;
	bit idling;
	int quiet_cycles = 0;
	int n_items;

	threshold_density_projection_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		idling = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// sink with random stall bursts
	always begin
		@(posedge clk);
		if (idling && $urandom_range(0, 9) == 0) begin
			m_axis_tready <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		m_axis_tready <= 1;
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) sb.note_density(s_axis_tdata[16:0]);
		if (m_axis_tvalid && m_axis_tready) sb.check_projection(m_axis_tdata, m_axis_tuser);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_density(input logic [16:0] d);
		if (idling && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {7'd0, d};
		do @(posedge clk); while (!s_axis_tready);
		n_items++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic random_densities(input int count);
		logic [16:0] d;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1: d = 17'($urandom);
				2: d = 17'($urandom_range(32760, 32768));
				3: d = 17'({1'b0, sb.eta[15:1]} + 17'($urandom_range(0, 4)) - 17'd2);
				default: d = 17'($urandom_range(0, 32768));
			endcase
			send_density(d);
		end
	endtask

	task automatic directed_densities();
		send_density(17'd0);
		send_density(17'd1);
		send_density(17'd16384);
		send_density(17'd32767);
		send_density(17'd32768);
		send_density(17'd32769);
		send_density(17'h0FFFF);
		send_density(17'h10000);
		send_density(17'h1FFFF);
		send_density({1'b0, sb.eta[15:1]});
		send_density({1'b0, sb.eta[15:1]} + 17'd1);
	endtask

	initial begin
		n_items = 0;
		@(posedge arst_n);
		@(posedge clk);
		directed_densities();
		random_densities(60);
		drain();
		write_reg(tdp_pkg::REG_SHARPNESS, 16'd0);
		directed_densities();
		random_densities(60);
		drain();
		write_reg(tdp_pkg::REG_SHARPNESS, 16'hFFFF);
		write_reg(tdp_pkg::REG_THRESHOLD, 16'd1);
		random_densities(80);
		drain();
		write_reg(tdp_pkg::REG_THRESHOLD, 16'hFFFF);
		directed_densities();
		random_densities(80);
		drain();
		write_reg(tdp_pkg::REG_THRESHOLD, 16'd0);
		write_reg(tdp_pkg::REG_SHARPNESS, 16'd2560);
		directed_densities();
		random_densities(40);
		drain();
		write_reg(2'd2, 16'd1234);
		write_reg(2'd3, 16'd4321);
		write_reg(tdp_pkg::REG_THRESHOLD, 16'(($urandom_range(1, 65535))));
		write_reg(tdp_pkg::REG_SHARPNESS, 16'($urandom_range(0, 8000)));
		random_densities(150);
		drain();
		write_reg(tdp_pkg::REG_THRESHOLD, 16'(($urandom_range(1, 65535))));
		write_reg(tdp_pkg::REG_SHARPNESS, 16'($urandom));
		random_densities(80);
		idling = 0;
		random_densities(60);
		s_axis_tvalid <= 0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("%0d densities sent, %0d results checked (%0d range errors)",
			n_items, sb.results_seen, sb.errors_seen);
		$display("settings covered sharpness 0 to max, threshold 0, 1, half and max");
		if (sb.mismatches == 0 && sb.exp_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
